### rtl/plq_pkg.sv
`timescale 1ns / 1ps
package plq_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int IDX_W = 11;
    localparam int COORD_W = 16;
    localparam int LEN_W = 27;
    localparam int DIST_W = 17;
    localparam int SUM_W = 29;
    localparam int DELTA_W = 20;
    localparam logic [IDX_W-1:0] CNT_RESET = 11'd1024;
    localparam logic [IDX_W-1:0] CNT_MIN = 11'd2;
    localparam logic [LEN_W-1:0] LEN_MAX = 27'h7FFFFFF;

    typedef enum logic {
        FUNC_MOVE  = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef enum logic {
        STATUS_OK  = 1'b0,
        STATUS_BAD = 1'b1
    } status_t;

    function automatic logic [DIST_W-1:0] man_dist(
        input logic signed [COORD_W-1:0] ax,
        input logic signed [COORD_W-1:0] ay,
        input logic signed [COORD_W-1:0] bx,
        input logic signed [COORD_W-1:0] by
    );
        logic signed [COORD_W:0] dx;
        logic signed [COORD_W:0] dy;
        logic [COORD_W:0] ux;
        logic [COORD_W:0] uy;
        dx = COORD_W'(0) + ({ax[COORD_W-1], ax} - {bx[COORD_W-1], bx});
        dy = ({ay[COORD_W-1], ay} - {by[COORD_W-1], by});
        ux = dx[COORD_W] ? COORD_W'(0) - dx : dx;
        uy = dy[COORD_W] ? COORD_W'(0) - dy : dy;
        return DIST_W'(ux + uy);
    endfunction

endpackage

### rtl/plq_in_if.sv
`timescale 1ns / 1ps
interface plq_in_if;
    import plq_pkg::*;
    logic valid;
    logic ready;
    logic func;
    logic [IDX_W-1:0] point_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [IDX_W-1:0] range_first;
    logic [IDX_W-1:0] range_last;

    modport source (output valid, func, point_index, coord_x, coord_y, range_first,
                    range_last, input ready);
    modport sink (input valid, func, point_index, coord_x, coord_y, range_first,
                  range_last, output ready);
endinterface

### rtl/plq_out_if.sv
`timescale 1ns / 1ps
interface plq_out_if;
    import plq_pkg::*;
    logic valid;
    logic ready;
    logic [LEN_W-1:0] path_length;
    logic status;

    modport source (output valid, path_length, status, input ready);
    modport sink (input valid, path_length, status, output ready);
endinterface

### rtl/plq_cfg_if.sv
`timescale 1ns / 1ps
interface plq_cfg_if;
    import plq_pkg::*;
    logic valid;
    logic ready;
    logic [IDX_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### rtl/plq_point_mem.sv
`timescale 1ns / 1ps
module plq_point_mem #(
    parameter int DEPTH = 1025,
    parameter int AW = 11,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### rtl/path_length_skip_one_query_engine_top.sv
`timescale 1ns / 1ps
// Path length query engine with one skipped point.
// Channels: in_ch carries move and query transactions, out_ch carries one
// result per query, cfg writes point_count. Each channel uses valid/ready.
// A move is written to the point memory in the cycle it is accepted; the next
// transaction can be taken in the cycle after. A query with a bad range goes
// straight to the result state without reading the memory. A good query
// streams its points out of the point memory, one point per cycle.
// The memory read port sets this rate.
// After reset the block clears the point memory, one entry per cycle, over all
// min(MAX_POINTS, 2047) + 1 entries (at most 2048), and holds in_ch.ready low meanwhile.
// point_count resets to 1024; configuration writes are taken at any time.
// The result sits in an output register. While the receiver stalls, the
// block keeps taking moves and starts the next query, which waits at its
// end until the output register is free.
module path_length_skip_one_query_engine_top #(
    parameter int MAX_POINTS = plq_pkg::MAX_POINTS_DEF
) (
    input logic clk,
    input logic rst_n,
    plq_in_if.sink in_ch,
    plq_out_if.source out_ch,
    plq_cfg_if.sink cfg
);
    import plq_pkg::*;

    localparam int CAP = (MAX_POINTS < 2047) ? MAX_POINTS : 2047;
    localparam int DEPTH = CAP + 1;
    localparam int AW = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_WALK  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] count_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] last_reg;
    logic [AW-1:0] proc_reg;
    logic issue_done_reg;
    logic dv_reg;
    logic [1:0] ph_reg;
    logic signed [COORD_W-1:0] p0x_reg, p0y_reg, p1x_reg, p1y_reg;
    logic [DIST_W-1:0] prev_leg_reg;
    logic [SUM_W-1:0] sum_reg;
    logic signed [DELTA_W-1:0] best_reg;
    logic err_reg;
    logic out_valid_reg;
    logic [LEN_W-1:0] len_reg;
    logic status_reg;

    logic [IDX_W-1:0] cnt;
    logic in_acc;
    logic move_ok;
    logic range_bad;
    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0] mem_wdata;
    logic mem_re;
    logic [31:0] mem_rdata;
    logic signed [COORD_W-1:0] qx, qy;
    logic [DIST_W-1:0] leg;
    logic [DIST_W-1:0] d0q;
    logic signed [DELTA_W-1:0] k;
    logic signed [SUM_W+1:0] tot;
    logic [LEN_W-1:0] len_final;
    logic load_out;

    assign cnt = (count_reg < CNT_MIN) ? CNT_MIN :
                 ((count_reg > IDX_W'(CAP)) ? IDX_W'(CAP) : count_reg);
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc = in_ch.valid && in_ch.ready;
    assign move_ok = (in_ch.func == FUNC_MOVE) && (in_ch.point_index != '0)
                     && (in_ch.point_index <= cnt);
    assign range_bad = (in_ch.range_first == '0) || (in_ch.range_last < in_ch.range_first)
                       || (in_ch.range_last > cnt);
    assign cfg.ready = 1'b1;

    assign mem_we = (state_reg == S_CLEAR) || (in_acc && move_ok);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_reg : in_ch.point_index[AW-1:0];
    assign mem_wdata = (state_reg == S_CLEAR) ? 32'd0 : {in_ch.coord_x, in_ch.coord_y};
    assign mem_re = (state_reg == S_WALK) && !issue_done_reg;

    plq_point_mem #(
        .DEPTH(DEPTH),
        .AW(AW),
        .DW(32)
    ) u_mem (
        .clk(clk),
        .we(mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re(mem_re),
        .raddr(addr_reg),
        .rdata(mem_rdata)
    );

    assign qx = mem_rdata[31:16];
    assign qy = mem_rdata[15:0];
    assign leg = man_dist(p1x_reg, p1y_reg, qx, qy);
    assign d0q = man_dist(p0x_reg, p0y_reg, qx, qy);
    assign k = $signed(DELTA_W'(d0q)) - $signed(DELTA_W'(prev_leg_reg))
               - $signed(DELTA_W'(leg));

    always_comb
    begin
        tot = $signed({2'b00, sum_reg}) + $signed({{(SUM_W+2-DELTA_W){best_reg[DELTA_W-1]}},
                                                    best_reg});
        if (tot < 0)
        begin
            len_final = '0;
        end
        else if (tot > $signed({{(SUM_W+2-LEN_W){1'b0}}, LEN_MAX}))
        begin
            len_final = LEN_MAX;
        end
        else
        begin
            len_final = tot[LEN_W-1:0];
        end
    end

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc && in_ch.func == FUNC_QUERY)
                begin
                    state_next = range_bad ? S_DONE : S_WALK;
                end
            end
            S_WALK:
            begin
                if (dv_reg && proc_reg == last_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            count_reg <= CNT_RESET;
            clr_reg <= '0;
            issue_done_reg <= 1'b0;
            dv_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                count_reg <= cfg.data;
            end
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (in_acc)
            begin
                issue_done_reg <= 1'b0;
            end
            else if (mem_re && addr_reg == last_reg)
            begin
                issue_done_reg <= 1'b1;
            end
            dv_reg <= mem_re;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            addr_reg <= in_ch.range_first[AW-1:0];
            proc_reg <= in_ch.range_first[AW-1:0];
            last_reg <= in_ch.range_last[AW-1:0];
            ph_reg <= 2'd0;
            sum_reg <= '0;
            best_reg <= '0;
            err_reg <= range_bad;
        end
        else
        begin
            if (mem_re)
            begin
                addr_reg <= addr_reg + AW'(1);
            end
            if (dv_reg)
            begin
                proc_reg <= proc_reg + AW'(1);
                p0x_reg <= p1x_reg;
                p0y_reg <= p1y_reg;
                p1x_reg <= qx;
                p1y_reg <= qy;
                prev_leg_reg <= leg;
                if (ph_reg != 2'd3)
                begin
                    ph_reg <= ph_reg + 2'd1;
                end
                if (ph_reg != 2'd0)
                begin
                    sum_reg <= sum_reg + SUM_W'(leg);
                end
                if (ph_reg == 2'd2 || (ph_reg == 2'd3 && k < best_reg))
                begin
                    best_reg <= k;
                end
            end
        end
        if (load_out)
        begin
            len_reg <= err_reg ? '0 : len_final;
            status_reg <= err_reg ? STATUS_BAD : STATUS_OK;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.path_length = len_reg;
    assign out_ch.status = status_reg;

`ifndef ASSERT_OFF
    a_bad_range_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_ch.func == FUNC_QUERY && range_bad) |=> state_reg == S_DONE)
        else $error("bad range query did not go to result");
    a_dv_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> state_reg == S_WALK)
        else $error("read data outside walk");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status == STATUS_BAD) |-> out_ch.path_length == '0)
        else $error("error result with nonzero length");
    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> !mem_we)
        else $error("memory write during walk");
`endif
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
    import plq_pkg::*;

    typedef struct packed {
        func_t                     func;
        logic [IDX_W-1:0]          point_index;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic [IDX_W-1:0]          range_first;
        logic [IDX_W-1:0]          range_last;
    } path_op_t;

    typedef struct packed {
        logic [LEN_W-1:0] path_length;
        status_t          status;
    } path_result_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;

    plq_in_if  in_ch ();
    plq_out_if out_ch ();
    plq_cfg_if cfg ();

    path_length_skip_one_query_engine_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    path_op_t     pending_ops[$];
    path_result_t expected_paths[$];
    int           pt_x[1025];
    int           pt_y[1025];
    int           model_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_off_cycles;
    int           idle_cycles;
    int           error_count;
    bit           cfg_busy;
    bit           cfg_done;
    bit           in_fire;
    logic [IDX_W-1:0] cfg_value;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int leg(int i, int j);
        int dx;
        int dy;
        dx = pt_x[i] - pt_x[j];
        dy = pt_y[i] - pt_y[j];
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return dx + dy;
    endfunction

    function automatic int clamp_count(int c);
        if (c < 2) return 2;
        if (c > 1024) return 1024;
        return c;
    endfunction

    task automatic apply_path_op(input path_op_t op);
        path_result_t res;
        longint sum;
        longint best;
        longint k;
        int cnt;
        int l;
        int r;
        cnt = clamp_count(model_count);
        if (op.func == FUNC_MOVE) begin
            if (op.point_index >= 1 && op.point_index <= cnt) begin
                pt_x[op.point_index] = op.coord_x;
                pt_y[op.point_index] = op.coord_y;
            end
            return;
        end
        l = op.range_first;
        r = op.range_last;
        if (l < 1 || r < l || r > cnt) begin
            res.path_length = '0;
            res.status = STATUS_BAD;
        end else begin
            sum = 0;
            best = 0;
            for (int i = l; i < r; i++) sum += leg(i, i + 1);
            for (int i = l; i + 2 <= r; i++) begin
                k = leg(i, i + 2) - leg(i, i + 1) - leg(i + 1, i + 2);
                if (i == l || k < best) best = k;
            end
            sum += best;
            if (sum < 0) sum = 0;
            if (sum > LEN_MAX) sum = LEN_MAX;
            res.path_length = sum[LEN_W-1:0];
            res.status = STATUS_OK;
        end
        expected_paths.push_back(res);
    endtask

    // hold the input handshake seen at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
            in_fire <= in_ch.valid && in_ch.ready;
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_fire) begin
            apply_path_op(pending_ops.pop_front());
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_ch.valid <= 1'b1;
                {in_ch.func, in_ch.point_index, in_ch.coord_x, in_ch.coord_y,
                 in_ch.range_first, in_ch.range_last} <= pending_ops[0];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end else if (!in_ch.valid && pending_ops.size() > 0 &&
                     $urandom_range(99) >= send_idle_pct) begin
            in_ch.valid <= 1'b1;
            {in_ch.func, in_ch.point_index, in_ch.coord_x, in_ch.coord_y,
             in_ch.range_first, in_ch.range_last} <= pending_ops[0];
        end
    end

    // receiver ready
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // config writer
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg.valid <= 1'b0;
            cfg_done <= 1'b0;
        end else if (cfg.valid && cfg.ready) begin
            cfg.valid <= 1'b0;
            cfg_done <= 1'b1;
        end else if (cfg_busy && !cfg.valid && !cfg_done) begin
            cfg.valid <= 1'b1;
            cfg.data <= cfg_value;
        end else if (!cfg_busy) begin
            cfg_done <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg.valid && cfg.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_ch.valid && out_ch.ready) begin
                if (expected_paths.size() == 0) begin
                    $error("unexpected transaction: path_length %0d status %0d",
                           out_ch.path_length, out_ch.status);
                    error_count++;
                end else begin
                    path_result_t exp_r;
                    exp_r = expected_paths.pop_front();
                    if (out_ch.path_length !== exp_r.path_length) begin
                        $error("path_length expected %0d actual %0d",
                               exp_r.path_length, out_ch.path_length);
                        error_count++;
                    end
                    if (out_ch.status !== exp_r.status) begin
                        $error("status expected %0d actual %0d",
                               exp_r.status, out_ch.status);
                        error_count++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic path_op_t move_op(int idx, int x, int y);
        path_op_t op;
        op = '0;
        op.func = FUNC_MOVE;
        op.point_index = IDX_W'(idx);
        op.coord_x = COORD_W'(x);
        op.coord_y = COORD_W'(y);
        return op;
    endfunction

    function automatic path_op_t query_op(int l, int r);
        path_op_t op;
        op = '0;
        op.func = FUNC_QUERY;
        op.range_first = IDX_W'(l);
        op.range_last = IDX_W'(r);
        op.point_index = IDX_W'($urandom);
        op.coord_x = COORD_W'($urandom);
        op.coord_y = COORD_W'($urandom);
        return op;
    endfunction

    function automatic int rand_coord(int spread);
        if ($urandom_range(7) == 0) return $urandom_range(1) ? 32767 : -32768;
        if (spread == 0) return $signed(16'($urandom));
        return $urandom_range(2 * spread) - spread;
    endfunction

    task automatic drain();
        wait (pending_ops.size() == 0 && !in_ch.valid);
        wait (expected_paths.size() == 0);
        repeat (1100) @(posedge clk);
    endtask

    task automatic write_count(int value);
        cfg_value = IDX_W'(value);
        cfg_busy = 1'b1;
        wait (cfg_done);
        @(posedge clk);
        cfg_busy = 1'b0;
        model_count = value;
        @(posedge clk);
    endtask

    task automatic random_phase(int n, int cnt_hint);
        int cnt;
        int l;
        int span;
        cnt = clamp_count(cnt_hint);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                    pending_ops.push_back(move_op($urandom_range(cnt, 1),
                        rand_coord(200), rand_coord(200)));
                4:
                    pending_ops.push_back(move_op($urandom_range(2047),
                        rand_coord(0), rand_coord(0)));
                5:
                    pending_ops.push_back(query_op($urandom_range(2047),
                        $urandom_range(2047)));
                default: begin
                    span = ($urandom_range(15) == 0) ? $urandom_range(cnt - 1)
                                                    : $urandom_range(12);
                    if (span > cnt - 1) span = cnt - 1;
                    l = $urandom_range(cnt - span, 1);
                    pending_ops.push_back(query_op(l, l + span));
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_MOVE;
        in_ch.point_index = '0;
        in_ch.coord_x = '0;
        in_ch.coord_y = '0;
        in_ch.range_first = '0;
        in_ch.range_last = '0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        cfg_busy = 1'b0;
        cfg_value = '0;
        model_count = 1024;
        hold_off_cycles = 0;
        idle_cycles = 0;
        error_count = 0;
        send_idle_pct = 24;
        recv_idle_pct = 77;
        for (int i = 0; i <= 1024; i++) begin
            pt_x[i] = 0;
            pt_y[i] = 0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        pending_ops.push_back(query_op(1, 1024));
        pending_ops.push_back(move_op(1, 32767, -32768));
        pending_ops.push_back(move_op(2, -32768, 32767));
        pending_ops.push_back(move_op(3, 32767, 32767));
        pending_ops.push_back(move_op(4, 0, 0));
        pending_ops.push_back(move_op(1024, -32768, -32768));
        pending_ops.push_back(move_op(1023, 32767, 32767));
        pending_ops.push_back(move_op(0, 5, 5));
        pending_ops.push_back(move_op(1025, 5, 5));
        pending_ops.push_back(move_op(2047, 5, 5));
        pending_ops.push_back(query_op(1, 4));
        pending_ops.push_back(query_op(2, 2));
        pending_ops.push_back(query_op(1, 2));
        pending_ops.push_back(query_op(1, 3));
        pending_ops.push_back(query_op(1022, 1024));
        pending_ops.push_back(query_op(0, 3));
        pending_ops.push_back(query_op(5, 4));
        pending_ops.push_back(query_op(1, 1025));
        pending_ops.push_back(query_op(2047, 2047));
        pending_ops.push_back(query_op(1, 1024));
        drain();

        write_count(0);
        pending_ops.push_back(move_op(3, 1, 1));
        pending_ops.push_back(move_op(2, 9, 9));
        pending_ops.push_back(query_op(1, 2));
        pending_ops.push_back(query_op(1, 3));
        random_phase(120, 2);
        drain();

        write_count(2047);
        random_phase(180, 1024);
        drain();

        write_count(16);
        hold_off_cycles = 600;
        random_phase(150, 16);
        drain();

        send_idle_pct = 77;
        recv_idle_pct = 24;
        write_count(1024);
        random_phase(150, 1024);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_count(7);
        random_phase(150, 7);
        drain();

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
